### design/i2cbm_pkg.sv
// Package for the I2C bit-level master core.
// Holds the request and phase codes and the field widths; no dependencies.
package i2cbm_pkg;

    localparam int REQ_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 4;
    localparam int BIT_W   = 3;

    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WAIT_ACK = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RD_ACK   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RD_NACK  = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE    = 3'd7;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ST_A     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ST_B     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SP_A     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SP_B     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SP_C     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_LOW   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WR_HIGH  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_ACK_UP   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ACK_POLL = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RD_HIGH  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_RD_LOW   = 4'd11;
    localparam logic [PHASE_W-1:0] PH_RA_SET   = 4'd12;
    localparam logic [PHASE_W-1:0] PH_RA_HIGH  = 4'd13;
    localparam logic [PHASE_W-1:0] PH_END_LOW  = 4'd14;

    localparam logic [BIT_W-1:0]  LAST_BIT      = 3'd7;
    localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd250;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

endpackage

### design/i2c_bit_level_master_core.sv
// I2C bit-level master core: tick-paced sequencer with registered result.
// Depends on i2cbm_pkg.
//
// Usage: every input item is one bus tick. tuser carries the request code
// (tick only, start, stop, write, wait ack, read+ack, read+nack), tdata the
// write byte and the sampled SDA level. Each accepted item yields exactly
// one result item with the SCL/SDA drive levels, SDA drive enable, busy,
// done, the last read byte and the ACK timeout flag, as they stand after
// that tick. A request given while a command is running is ignored.
// The result is registered and becomes valid in the cycle after acceptance.
// Throughput: one item per cycle; the sequencer step is a single pass of
// logic between the state registers and the result register.
// If the receiver stalls, the result register holds its item and a new
// input is taken only in a cycle where that register empties or is free.
// The cfg channel sets the ACK timeout limit (reset 250) and is always
// ready; write it only while the core is idle.
// Reset (synchronous, active low): phase idle, SCL and SDA high and driven,
// counters, read byte and timeout flag cleared, output register empty.
module i2c_bit_level_master_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [7:0] write_data, [8] sda_in, [15:9] zero
    input  logic [i2cbm_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [2:0] req_type
    input  logic [i2cbm_pkg::REQ_W-1:0]        i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res,
    // [4] done_res, [12:5] read_data, [13] ack_timeout, [15:14] zero
    output logic [i2cbm_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [i2cbm_pkg::BYTE_W-1:0]       i_cfg_data
);
    import i2cbm_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase, w_phase;
    logic [REQ_W-1:0]   r_cmd, n_cmd;
    logic [BIT_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [BYTE_W-1:0]  r_shift, n_shift, w_shift;
    logic [BYTE_W-1:0]  r_poll, n_poll;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic               r_drive, n_drive;
    logic               r_timeout, n_timeout;
    logic [BYTE_W-1:0]  r_last_rd, n_last_rd;
    logic [BYTE_W-1:0]  r_limit;
    logic               n_done;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [REQ_W-1:0]  w_req;
    logic [BYTE_W-1:0] w_wdata;
    logic              w_sda_in;
    logic              w_accept;
    logic              w_start_cmd;

    assign w_req    = i_s_tuser;
    assign w_wdata  = i_s_tdata[BYTE_W-1:0];
    assign w_sda_in = i_s_tdata[BYTE_W];

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign w_start_cmd = (r_phase == PH_IDLE) && (w_req != REQ_TICK) && (w_req != REQ_SPARE);

    always_comb begin
        w_phase   = r_phase;
        w_shift   = r_shift;
        n_cmd     = r_cmd;
        n_bit_cnt = r_bit_cnt;
        n_timeout = r_timeout;
        if (w_start_cmd) begin
            n_cmd     = w_req;
            n_bit_cnt = '0;
            unique case (w_req)
                REQ_START: w_phase = PH_ST_A;
                REQ_STOP:  w_phase = PH_SP_A;
                REQ_WRITE: begin
                    w_phase = PH_WR_LOW;
                    w_shift = w_wdata;
                end
                REQ_WAIT_ACK: begin
                    w_phase   = PH_ACK_UP;
                    n_timeout = 1'b0;
                end
                default: begin
                    w_phase = PH_RD_HIGH;
                    w_shift = '0;
                end
            endcase
        end

        n_phase   = w_phase;
        n_shift   = w_shift;
        n_poll    = r_poll;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_drive   = r_drive;
        n_last_rd = r_last_rd;
        n_done    = 1'b0;

        unique case (w_phase)
            PH_IDLE: ;
            PH_ST_A: begin
                n_drive = 1'b1;
                n_sda   = 1'b1;
                n_scl   = 1'b1;
                n_phase = PH_ST_B;
            end
            PH_ST_B: begin
                n_sda   = 1'b0;
                n_phase = PH_END_LOW;
            end
            PH_SP_A: begin
                n_drive = 1'b1;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_phase = PH_SP_B;
            end
            PH_SP_B: begin
                n_scl   = 1'b1;
                n_phase = PH_SP_C;
            end
            PH_SP_C: begin
                n_sda   = 1'b1;
                n_done  = 1'b1;
                n_phase = PH_IDLE;
            end
            PH_WR_LOW: begin
                n_drive = 1'b1;
                n_scl   = 1'b0;
                n_sda   = w_shift[BYTE_W-1];
                n_phase = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
                n_scl   = 1'b1;
                n_shift = {w_shift[BYTE_W-2:0], 1'b0};
                if (r_bit_cnt == LAST_BIT) begin
                    n_bit_cnt = '0;
                    n_phase   = PH_END_LOW;
                end else begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    n_phase   = PH_WR_LOW;
                end
            end
            PH_ACK_UP: begin
                n_drive = 1'b0;
                n_sda   = 1'b1;
                n_scl   = 1'b1;
                n_poll  = '0;
                n_phase = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
                if (!w_sda_in) begin
                    n_scl   = 1'b0;
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end else if (r_poll >= r_limit) begin
                    n_timeout = 1'b1;
                    n_phase   = PH_SP_A;
                end else begin
                    n_poll = r_poll + 1'b1;
                end
            end
            PH_RD_HIGH: begin
                n_drive = 1'b0;
                n_sda   = 1'b1;
                n_scl   = 1'b1;
                n_phase = PH_RD_LOW;
            end
            PH_RD_LOW: begin
                n_shift = {w_shift[BYTE_W-2:0], w_sda_in};
                n_scl   = 1'b0;
                if (r_bit_cnt == LAST_BIT) begin
                    n_bit_cnt = '0;
                    n_last_rd = {w_shift[BYTE_W-2:0], w_sda_in};
                    n_phase   = PH_RA_SET;
                end else begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    n_phase   = PH_RD_HIGH;
                end
            end
            PH_RA_SET: begin
                n_drive = 1'b1;
                n_scl   = 1'b0;
                n_sda   = (r_cmd == REQ_RD_NACK);
                n_phase = PH_RA_HIGH;
            end
            PH_RA_HIGH: begin
                n_scl   = 1'b1;
                n_phase = PH_END_LOW;
            end
            PH_END_LOW: begin
                n_scl   = 1'b0;
                n_done  = 1'b1;
                n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cmd     <= REQ_TICK;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_poll    <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_drive   <= 1'b1;
            r_timeout <= 1'b0;
            r_last_rd <= '0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_poll    <= n_poll;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_drive   <= n_drive;
            r_timeout <= n_timeout;
            r_last_rd <= n_last_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {2'b00, n_timeout, n_last_rd, n_done,
                           (n_phase != PH_IDLE), n_drive, n_sda, n_scl};
        end
    end

`ifndef ASSERT_OFF
    // a finished command never reports busy in the same item
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[4] |-> !r_out_data[3])
        else $error("done raised while still busy");

    // SCL held high with SDA released for the whole ACK poll
    a_ack_poll_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ACK_POLL |-> r_scl && !r_drive)
        else $error("bus lines wrong during ACK poll");

    // bit counter only moves inside a byte transfer
    a_bit_cnt_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt != '0 |-> (r_phase == PH_WR_LOW || r_phase == PH_WR_HIGH ||
                             r_phase == PH_RD_HIGH || r_phase == PH_RD_LOW))
        else $error("bit counter outside byte transfer");

    a_poll_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ACK_POLL |-> r_poll <= r_limit)
        else $error("poll count past limit");

    // a timeout always hands over to the stop sequence
    a_timeout_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_timeout) |-> r_phase == PH_SP_A)
        else $error("timeout without stop");
`endif

endmodule
